// ----- sv/dtq_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_pkg
// Shared types, codes and constants of the deadline timer queue.
// ----------------------------------------------------------------------------
package dtq_pkg;

  localparam int DEF_TIMER_SLOTS = 16;
  localparam int MAX_RESULTS     = 16;
  localparam int RES_W           = $clog2(MAX_RESULTS + 1);

  localparam logic [1:0] MODE_SCHED  = 2'd0;
  localparam logic [1:0] MODE_CANCEL = 2'd1;
  localparam logic [1:0] MODE_TICK   = 2'd2;

  localparam logic [1:0] KIND_SCHED  = 2'd0;
  localparam logic [1:0] KIND_CANCEL = 2'd1;
  localparam logic [1:0] KIND_EXPIRY = 2'd2;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_DISABLED  = 2'd1;
  localparam logic [1:0] STAT_FULL      = 2'd2;
  localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

  localparam logic [31:0] ID_MAX = 32'hFFFF_FFFF;
  localparam logic [31:0] ID_FIRST = 32'd1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [31:0] delay;
    logic [31:0] target_id;
  } dtq_req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [31:0] tmr_id;
    logic [1:0]  status;
    logic        last;
  } dtq_rsp_t;

  typedef struct packed {
    logic [31:0] ident;
    logic [63:0] deadline;
  } slot_entry_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCHED,
    ST_CANCEL,
    ST_TICK,
    ST_TICK_LAST
  } ctl_state_t;

  typedef struct packed {
    logic capture;
    logic scan_reset;
    logic scan_run;
    logic sched;
    logic cancel_rsp;
    logic tick_start;
    logic tick_resolve;
    logic tick_last;
  } ctl_cmd_t;

  typedef struct packed {
    logic enabled;
    logic scan_done;
    logic found;
    logic limit;
  } dp_sts_t;

endpackage
`default_nettype wire

// ----- sv/dtq_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_ctrl
// Sequencer: accepts a request, steps slot scans and issues responses.
// ----------------------------------------------------------------------------
module dtq_ctrl import dtq_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  input  wire logic [1:0] mode,
  input  wire dp_sts_t    sts,
  output ctl_cmd_t        cmd,
  output logic            busy
);

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture    = 1'b1;
          cmd.scan_reset = 1'b1;
          unique case (mode)
            MODE_SCHED:  state_nxt = ST_SCHED;
            MODE_CANCEL: state_nxt = ST_CANCEL;
            MODE_TICK: begin
              cmd.tick_start = 1'b1;
              state_nxt      = ST_TICK;
            end
            default: state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_SCHED: begin
        cmd.sched = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_CANCEL: begin
        if (!sts.enabled || sts.scan_done) begin
          cmd.cancel_rsp = 1'b1;
          state_nxt      = ST_IDLE;
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      ST_TICK: begin
        if (sts.scan_done) begin
          cmd.tick_resolve = 1'b1;
          cmd.scan_reset   = 1'b1;
          if (!sts.found) begin
            state_nxt = ST_IDLE;
          end else if (sts.limit) begin
            state_nxt = ST_TICK_LAST;
          end
        end else begin
          cmd.scan_run = 1'b1;
        end
      end
      ST_TICK_LAST: begin
        cmd.tick_last = 1'b1;
        state_nxt     = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy = (state_r != ST_IDLE);

endmodule
`default_nettype wire

// ----- sv/dtq_datapath.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_datapath
// Timer slot memory, valid bits, time count, scan compare and result register.
// ----------------------------------------------------------------------------
module dtq_datapath import dtq_pkg::*; #(
  parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     cfg_we,
  input  wire logic     cfg_wdata,
  input  wire dtq_req_t in_req,
  input  wire ctl_cmd_t cmd,
  output dp_sts_t       sts,
  output logic          out_valid,
  output dtq_rsp_t      out_rsp
);

  localparam int IDX_W = (TIMER_SLOTS > 1) ? $clog2(TIMER_SLOTS) : 1;
  localparam int CNT_W = $clog2(TIMER_SLOTS + 1);

  slot_entry_t mem [TIMER_SLOTS];
  slot_entry_t rd_data_r;
  slot_entry_t wr_data;
  logic        mem_we;
  logic [IDX_W-1:0] raddr;

  logic                   enabled_r;
  dtq_req_t               req_r;
  logic [TIMER_SLOTS-1:0] valid_r;
  logic [63:0]            now_r;
  logic [31:0]            next_id_r;
  logic [CNT_W-1:0]       idx_r;
  logic                   chk_v_r;
  logic [IDX_W-1:0]       chk_idx_r;
  logic                   found_r;
  logic [IDX_W-1:0]       best_idx_r;
  logic [63:0]            best_dl_r;
  logic [31:0]            best_id_r;
  logic                   pend_v_r;
  logic [31:0]            pend_id_r;
  logic [RES_W-1:0]       cnt_r;
  logic                   out_valid_r;
  dtq_rsp_t               out_rsp_r;

  logic             free_any;
  logic [IDX_W-1:0] free_idx;
  logic             chk_live;
  logic             due;
  logic             earlier;
  logic             cancel_hit;
  logic             take;
  logic [RES_W-1:0] emitted;

  always_comb begin
    free_any = 1'b0;
    free_idx = '0;
    for (int i = TIMER_SLOTS - 1; i >= 0; i--) begin
      if (!valid_r[i]) begin
        free_any = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  assign raddr   = idx_r[IDX_W-1:0];
  assign mem_we  = cmd.sched && enabled_r && free_any;
  assign wr_data = '{ident: next_id_r, deadline: now_r + {32'd0, req_r.delay}};

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[free_idx] <= wr_data;
    end
    rd_data_r <= mem[raddr];
  end

  assign chk_live   = valid_r[chk_idx_r];
  assign due        = chk_live && (rd_data_r.deadline <= now_r);
  assign earlier    = !found_r || (rd_data_r.deadline < best_dl_r) ||
                      ((rd_data_r.deadline == best_dl_r) && (rd_data_r.ident < best_id_r));
  assign cancel_hit = chk_live && !found_r && (req_r.target_id != 32'd0) &&
                      (rd_data_r.ident == req_r.target_id);
  assign take       = chk_v_r && ((req_r.mode == MODE_CANCEL) ? cancel_hit : (due && earlier));
  assign emitted    = cnt_r + RES_W'(pend_v_r);

  assign sts = '{
    enabled:   enabled_r,
    scan_done: (idx_r == CNT_W'(TIMER_SLOTS)) && !chk_v_r,
    found:     found_r,
    limit:     (emitted == RES_W'(MAX_RESULTS - 1))
  };

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enabled_r   <= 1'b0;
      valid_r     <= '0;
      now_r       <= '0;
      next_id_r   <= ID_FIRST;
      idx_r       <= '0;
      chk_v_r     <= 1'b0;
      found_r     <= 1'b0;
      pend_v_r    <= 1'b0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.sched || cmd.cancel_rsp || cmd.tick_last ||
                     (cmd.tick_resolve && pend_v_r);
      if (cfg_we) begin
        enabled_r <= cfg_wdata;
      end
      if (cmd.capture) begin
        req_r <= in_req;
      end
      if (cmd.scan_run) begin
        if (idx_r < CNT_W'(TIMER_SLOTS)) begin
          idx_r     <= idx_r + CNT_W'(1);
          chk_v_r   <= 1'b1;
          chk_idx_r <= idx_r[IDX_W-1:0];
        end else begin
          chk_v_r <= 1'b0;
        end
        if (take) begin
          found_r    <= 1'b1;
          best_idx_r <= chk_idx_r;
          best_dl_r  <= rd_data_r.deadline;
          best_id_r  <= rd_data_r.ident;
        end
      end
      if (cmd.tick_start) begin
        now_r    <= now_r + 64'd1;
        pend_v_r <= 1'b0;
        cnt_r    <= '0;
      end
      if (cmd.sched) begin
        out_rsp_r.kind <= KIND_SCHED;
        out_rsp_r.last <= 1'b1;
        if (!enabled_r) begin
          out_rsp_r.status <= STAT_DISABLED;
          out_rsp_r.tmr_id <= '0;
        end else if (!free_any) begin
          out_rsp_r.status <= STAT_FULL;
          out_rsp_r.tmr_id <= '0;
        end else begin
          out_rsp_r.status  <= STAT_OK;
          out_rsp_r.tmr_id  <= next_id_r;
          valid_r[free_idx] <= 1'b1;
          next_id_r         <= (next_id_r == ID_MAX) ? ID_FIRST : next_id_r + 32'd1;
        end
      end
      if (cmd.cancel_rsp) begin
        out_rsp_r.kind <= KIND_CANCEL;
        out_rsp_r.last <= 1'b1;
        if (!enabled_r) begin
          out_rsp_r.status <= STAT_DISABLED;
          out_rsp_r.tmr_id <= '0;
        end else if (found_r) begin
          out_rsp_r.status    <= STAT_OK;
          out_rsp_r.tmr_id    <= req_r.target_id;
          valid_r[best_idx_r] <= 1'b0;
        end else begin
          out_rsp_r.status <= STAT_NOT_FOUND;
          out_rsp_r.tmr_id <= '0;
        end
      end
      if (cmd.tick_resolve) begin
        out_rsp_r.kind   <= KIND_EXPIRY;
        out_rsp_r.status <= STAT_OK;
        out_rsp_r.tmr_id <= pend_id_r;
        if (found_r) begin
          out_rsp_r.last      <= 1'b0;
          cnt_r               <= emitted;
          pend_v_r            <= 1'b1;
          pend_id_r           <= best_id_r;
          valid_r[best_idx_r] <= 1'b0;
        end else begin
          out_rsp_r.last <= 1'b1;
          pend_v_r       <= 1'b0;
        end
      end
      if (cmd.tick_last) begin
        out_rsp_r.kind   <= KIND_EXPIRY;
        out_rsp_r.status <= STAT_OK;
        out_rsp_r.tmr_id <= pend_id_r;
        out_rsp_r.last   <= 1'b1;
        pend_v_r         <= 1'b0;
      end
      if (cmd.scan_reset) begin
        idx_r   <= '0;
        chk_v_r <= 1'b0;
        found_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule
`default_nettype wire

// ----- sv/deadline_timer_queue_core.sv -----
`timescale 1ns / 1ps
`default_nettype none
// A schedule reply goes from the SCHED state through the result register;
// a cancel scans every slot unless disabled. A tick rescans the slot memory,
// one slot per cycle, until a scan finds no due timer or MAX_RESULTS expire.
// One request at a time; busy is high until its last result is commanded.
// Synchronous active-low reset clears all valid bits, the time count and
// sets the next id to 1. Results are strobes; the receiver cannot stall.
// ----------------------------------------------------------------------------
// deadline_timer_queue_core
// One-shot timer table with deadline-ordered expiry.
// ----------------------------------------------------------------------------
module deadline_timer_queue_core import dtq_pkg::*; #(
  parameter int TIMER_SLOTS = DEF_TIMER_SLOTS
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  input  wire dtq_req_t in_req,
  output logic          busy,
  output logic          out_valid,
  output dtq_rsp_t      out_rsp,
  input  wire logic     cfg_we,
  input  wire logic     cfg_wdata
);

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  dtq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .mode  (in_req.mode),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  dtq_datapath #(
    .TIMER_SLOTS (TIMER_SLOTS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_req    (in_req),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_rsp   (out_rsp)
  );

endmodule
`default_nettype wire

// ----- sv/dtq_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// dtq_checker
// Port-level checks of the deadline timer queue.
// ----------------------------------------------------------------------------
module dtq_checker import dtq_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     start,
  input wire dtq_req_t in_req,
  input wire logic     busy,
  input wire logic     out_valid,
  input wire dtq_rsp_t out_rsp
);

  a_no_result_after_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result strobe right after reset");

  a_reply_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.kind != KIND_EXPIRY) |-> out_rsp.last)
    else $error("reply not marked last");

  a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.kind == KIND_EXPIRY) |-> (out_rsp.status == STAT_OK))
    else $error("expiry with nonzero status");

  a_fail_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_rsp.status != STAT_OK) |-> (out_rsp.tmr_id == 32'd0))
    else $error("failed request returned an id");

  a_sched_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && (in_req.mode == MODE_SCHED) |=> busy)
    else $error("schedule request not taken");

endmodule

bind deadline_timer_queue_core dtq_checker u_dtq_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .in_req    (in_req),
  .busy      (busy),
  .out_valid (out_valid),
  .out_rsp   (out_rsp)
);
`default_nettype wire
